>>> design/pbc_pkg.sv
// Shared widths, payload types and fixed-point helpers of the pi branch current block.
package pbc_pkg;

   localparam int DW   = 32;              // data width
   localparam int FB   = 28;              // fractional bits
   localparam int PW   = 2 * DW;          // exact product
   localparam int SW   = 2 * DW + 3;      // sum of four products
   localparam int DENW = 2 * DW;          // r^2 + x^2
   localparam int QW   = DW + 1;          // quotient bits resolved by the divider
   localparam int NW   = DW + 2 * FB;     // numerator |p| << 2F
   localparam int RW0  = 3 * DW + 2;
   localparam int RW   = ((RW0 > NW) ? RW0 : NW) + 1;

   typedef logic signed [DW-1:0] word_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [SW-1:0] sum_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ZERO = 2'd1,
      ST_SAT  = 2'd2
   } status_type;

   typedef struct packed {
      word_type val;
      logic     ovf;
   } sat_type;

   // fields that ride alongside the divider
   typedef struct packed {
      logic     zero;
      logic     ovf;
      word_type bsh;
      word_type tr;
      word_type ti;
      word_type vkr;
      word_type vki;
      word_type vmr;
      word_type vmi;
      word_type t2;
   } side_type;

   typedef struct packed {
      logic            valid;
      logic            neg_g;
      logic            neg_b;
      logic [DENW-1:0] den;
      logic [NW-1:0]   num_g;
      logic [NW-1:0]   num_b;
      side_type        side;
   } div_in_type;

   typedef struct packed {
      logic     valid;
      word_type g;
      word_type b;
      logic     ovf;
      side_type side;
   } div_out_type;

   localparam sum_type HALF = SW'(1) <<< (FB - 1);

   function automatic sat_type sat_w(input sum_type v);
      sat_type r;
      r.ovf = !((&v[SW-1:DW-1]) || !(|v[SW-1:DW-1]));
      if (!r.ovf) begin
         r.val = v[DW-1:0];
      end else if (v[SW-1]) begin
         r.val = {1'b1, {(DW-1){1'b0}}};
      end else begin
         r.val = {1'b0, {(DW-1){1'b1}}};
      end
      return r;
   endfunction

   // round half up, drop FB fraction bits, saturate
   function automatic sat_type quant(input sum_type v);
      sum_type t;
      t = v + HALF;
      t = t >>> FB;
      return sat_w(t);
   endfunction

endpackage

>>> design/pbc_if.sv
// Request and response channel interfaces of the pi branch current block.
interface pbc_req_if;
   logic              valid;
   logic              ready;
   pbc_pkg::word_type series_r;
   pbc_pkg::word_type series_x;
   pbc_pkg::word_type shunt_b;
   pbc_pkg::word_type tap_re;
   pbc_pkg::word_type tap_im;
   pbc_pkg::word_type vk_re;
   pbc_pkg::word_type vk_im;
   pbc_pkg::word_type vm_re;
   pbc_pkg::word_type vm_im;
   modport source (output valid, series_r, series_x, shunt_b, tap_re, tap_im,
                   vk_re, vk_im, vm_re, vm_im, input ready);
   modport sink (input valid, series_r, series_x, shunt_b, tap_re, tap_im,
                 vk_re, vk_im, vm_re, vm_im, output ready);
endinterface

interface pbc_rsp_if;
   logic              valid;
   logic              ready;
   pbc_pkg::word_type ikm_re;
   pbc_pkg::word_type ikm_im;
   pbc_pkg::word_type imk_re;
   pbc_pkg::word_type imk_im;
   logic [1:0]        status;
   modport source (output valid, ikm_re, ikm_im, imk_re, imk_im, status, input ready);
   modport sink (input valid, ikm_re, ikm_im, imk_re, imk_im, status, output ready);
endinterface

>>> design/pbc_div.sv
// Pipelined restoring divider giving the rounded, signed, saturated admittance g and b.
module pbc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  pbc_pkg::div_in_type  din,
   output pbc_pkg::div_out_type dout
);

   localparam int NST = pbc_pkg::QW + 1;
   localparam int MW  = pbc_pkg::DW + 2;

   typedef struct packed {
      logic [pbc_pkg::DENW-1:0] den;
      logic [pbc_pkg::RW-1:0]   rem_g;
      logic [pbc_pkg::RW-1:0]   rem_b;
      logic [pbc_pkg::QW-1:0]   q_g;
      logic [pbc_pkg::QW-1:0]   q_b;
      logic                     ovf_g;
      logic                     ovf_b;
      logic                     neg_g;
      logic                     neg_b;
      pbc_pkg::side_type        side;
   } dstage_type;

   dstage_type           st_ff [NST];
   dstage_type           st_in [NST];
   logic [NST-1:0]       vld_ff;
   pbc_pkg::div_out_type dout_ff;
   pbc_pkg::div_out_type dout_in;

   function automatic pbc_pkg::sat_type adm_sat(input logic [MW-1:0] mag, input logic neg,
                                                input logic ovf);
      pbc_pkg::sat_type r;
      logic             big;
      big = ovf || (neg ? (mag > (MW'(1) << (pbc_pkg::DW - 1)))
                        : (mag > ((MW'(1) << (pbc_pkg::DW - 1)) - MW'(1))));
      r.ovf = big;
      if (big) begin
         r.val = neg ? {1'b1, {(pbc_pkg::DW-1){1'b0}}} : {1'b0, {(pbc_pkg::DW-1){1'b1}}};
      end else begin
         r.val = neg ? pbc_pkg::DW'(~mag + MW'(1)) : pbc_pkg::DW'(mag);
      end
      return r;
   endfunction

   // quotient beyond QW bits saturates whatever the low bits say
   always_comb begin
      logic [pbc_pkg::RW-1:0] lim;
      lim               = pbc_pkg::RW'(din.den) << pbc_pkg::QW;
      st_in[0].den      = din.den;
      st_in[0].rem_g    = pbc_pkg::RW'(din.num_g);
      st_in[0].rem_b    = pbc_pkg::RW'(din.num_b);
      st_in[0].q_g      = '0;
      st_in[0].q_b      = '0;
      st_in[0].ovf_g    = pbc_pkg::RW'(din.num_g) >= lim;
      st_in[0].ovf_b    = pbc_pkg::RW'(din.num_b) >= lim;
      st_in[0].neg_g    = din.neg_g;
      st_in[0].neg_b    = din.neg_b;
      st_in[0].side     = din.side;
   end

   for (genvar j = 1; j < NST; j++) begin : g_step
      localparam int K = pbc_pkg::QW - j;
      always_comb begin
         logic [pbc_pkg::RW-1:0] trial;
         trial    = pbc_pkg::RW'(st_ff[j-1].den) << K;
         st_in[j] = st_ff[j-1];
         if (st_ff[j-1].rem_g >= trial) begin
            st_in[j].rem_g = st_ff[j-1].rem_g - trial;
            st_in[j].q_g[K] = 1'b1;
         end
         if (st_ff[j-1].rem_b >= trial) begin
            st_in[j].rem_b = st_ff[j-1].rem_b - trial;
            st_in[j].q_b[K] = 1'b1;
         end
      end
   end

   // ties away from zero: bump when 2*rem >= den
   always_comb begin
      dstage_type       last;
      logic             rnd_g;
      logic             rnd_b;
      pbc_pkg::sat_type sg;
      pbc_pkg::sat_type sb;
      last  = st_ff[NST-1];
      rnd_g = {last.rem_g[pbc_pkg::RW-2:0], 1'b0} >= pbc_pkg::RW'(last.den);
      rnd_b = {last.rem_b[pbc_pkg::RW-2:0], 1'b0} >= pbc_pkg::RW'(last.den);
      sg    = adm_sat(MW'(last.q_g) + MW'(rnd_g), last.neg_g, last.ovf_g);
      sb    = adm_sat(MW'(last.q_b) + MW'(rnd_b), last.neg_b, last.ovf_b);
      dout_in.valid = vld_ff[NST-1];
      dout_in.g     = sg.val;
      dout_in.b     = sb.val;
      dout_in.ovf   = sg.ovf || sb.ovf;
      dout_in.side  = last.side;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
      if (reset) begin
         vld_ff        <= '0;
         dout_ff.valid <= 1'b0;
      end else if (en) begin
         vld_ff  <= {vld_ff[NST-2:0], din.valid};
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff) && $stable(dout_ff.valid))
      else $error("divider pipeline moved while stalled");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      en && din.valid |=> vld_ff[0])
      else $error("divider lost a request on entry");
   a_out: assert property (@(posedge clock) disable iff (reset)
      en |=> dout_ff.valid == $past(vld_ff[NST-1]))
      else $error("divider output valid out of step");

endmodule

>>> design/pi_branch_current_core.sv
// Pi-model branch current core: admittance, tap terms and the two branch end currents.
//
// One request carries a branch (r, x, shunt b, complex tap t) and the bus voltages Ek and
// Em, all signed Q4.28. One response carries Ikm, Imk and a status: ok, zero impedance
// (currents forced to zero) or saturated (some intermediate or result clamped).
// Both channels use valid/ready; a request is taken when both are high.
// The block is a single pipeline with valid bits: a new request may enter every cycle
// while the response is not stalled, so the sustained rate is one branch per cycle.
// The pipelined divider forming 1/(r + jx) resolves one quotient bit per stage and
// holds most of the pipeline registers.
// The response is held in an output register. When the receiver stalls with a response
// waiting, the whole pipeline holds and req ready drops; nothing is lost or repeated,
// and a request is taken again in the same cycle that the response leaves.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
module pi_branch_current_core (
   input  logic      clock,
   input  logic      reset,
   pbc_req_if.sink   req_ch,
   pbc_rsp_if.source rsp_ch
);

   typedef struct packed {
      pbc_pkg::word_type r;
      pbc_pkg::word_type x;
      pbc_pkg::word_type bsh;
      pbc_pkg::word_type tr;
      pbc_pkg::word_type ti;
      pbc_pkg::word_type vkr;
      pbc_pkg::word_type vki;
      pbc_pkg::word_type vmr;
      pbc_pkg::word_type vmi;
   } s1_type;

   typedef struct packed {
      logic                   zero;
      logic                   neg_g;
      logic                   neg_b;
      logic [pbc_pkg::PW-1:0] r2;
      logic [pbc_pkg::PW-1:0] x2;
      pbc_pkg::prod_type      tr2;
      pbc_pkg::prod_type      ti2;
      logic [pbc_pkg::NW-1:0] num_g;
      logic [pbc_pkg::NW-1:0] num_b;
      pbc_pkg::word_type      bsh;
      pbc_pkg::word_type      tr;
      pbc_pkg::word_type      ti;
      pbc_pkg::word_type      vkr;
      pbc_pkg::word_type      vki;
      pbc_pkg::word_type      vmr;
      pbc_pkg::word_type      vmi;
   } s2_type;

   typedef struct packed {
      logic              zero;
      logic              ovf;
      pbc_pkg::word_type g;
      pbc_pkg::word_type bsh;
      pbc_pkg::word_type eim;
      pbc_pkg::word_type vkr;
      pbc_pkg::word_type vki;
      pbc_pkg::word_type vmr;
      pbc_pkg::word_type vmi;
      pbc_pkg::prod_type pa;
      pbc_pkg::prod_type pb;
      pbc_pkg::prod_type p1;
      pbc_pkg::prod_type p2;
      pbc_pkg::prod_type p3;
      pbc_pkg::prod_type p4;
   } s4_type;

   typedef struct packed {
      logic              zero;
      logic              ovf;
      pbc_pkg::word_type g;
      pbc_pkg::word_type eim;
      pbc_pkg::word_type are;
      pbc_pkg::word_type aim;
      pbc_pkg::word_type ccr;
      pbc_pkg::word_type cci;
      pbc_pkg::word_type cdr;
      pbc_pkg::word_type cdi;
      pbc_pkg::word_type vkr;
      pbc_pkg::word_type vki;
      pbc_pkg::word_type vmr;
      pbc_pkg::word_type vmi;
   } s5_type;

   typedef struct packed {
      logic              zero;
      logic              ovf;
      pbc_pkg::prod_type m0;
      pbc_pkg::prod_type m1;
      pbc_pkg::prod_type m2;
      pbc_pkg::prod_type m3;
      pbc_pkg::prod_type m4;
      pbc_pkg::prod_type m5;
      pbc_pkg::prod_type m6;
      pbc_pkg::prod_type m7;
      pbc_pkg::prod_type m8;
      pbc_pkg::prod_type m9;
      pbc_pkg::prod_type m10;
      pbc_pkg::prod_type m11;
      pbc_pkg::prod_type m12;
      pbc_pkg::prod_type m13;
      pbc_pkg::prod_type m14;
      pbc_pkg::prod_type m15;
   } s6_type;

   typedef struct packed {
      logic             zero;
      logic             ovf;
      pbc_pkg::sum_type ikr;
      pbc_pkg::sum_type iki;
      pbc_pkg::sum_type imr;
      pbc_pkg::sum_type imi;
   } s7_type;

   logic                 en;
   logic                 v1_ff, v2_ff, v4_ff, v5_ff, v6_ff, v7_ff, out_vld_ff;
   s1_type               s1_ff, s1_in;
   s2_type               s2_ff, s2_in;
   pbc_pkg::div_in_type  div_in_ff, div_in_in;
   pbc_pkg::div_out_type dout;
   s4_type               s4_ff, s4_in;
   s5_type               s5_ff, s5_in;
   s6_type               s6_ff, s6_in;
   s7_type               s7_ff, s7_in;
   pbc_pkg::word_type    ikm_re_ff, ikm_im_ff, imk_re_ff, imk_im_ff;
   pbc_pkg::word_type    ikm_re_in, ikm_im_in, imk_re_in, imk_im_in;
   pbc_pkg::status_type  status_ff, status_in;

   assign en           = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   always_comb begin
      s1_in.r   = req_ch.series_r;
      s1_in.x   = req_ch.series_x;
      s1_in.bsh = req_ch.shunt_b;
      s1_in.tr  = req_ch.tap_re;
      s1_in.ti  = req_ch.tap_im;
      s1_in.vkr = req_ch.vk_re;
      s1_in.vki = req_ch.vk_im;
      s1_in.vmr = req_ch.vm_re;
      s1_in.vmi = req_ch.vm_im;
   end

   // magnitudes and squares
   always_comb begin
      logic [pbc_pkg::DW-1:0] ur;
      logic [pbc_pkg::DW-1:0] ux;
      ur = s1_ff.r[pbc_pkg::DW-1] ? (~s1_ff.r + 1'b1) : s1_ff.r;
      ux = s1_ff.x[pbc_pkg::DW-1] ? (~s1_ff.x + 1'b1) : s1_ff.x;
      s2_in.zero  = (s1_ff.r == '0) && (s1_ff.x == '0);
      s2_in.neg_g = s1_ff.r[pbc_pkg::DW-1];
      s2_in.neg_b = !s1_ff.x[pbc_pkg::DW-1] && (s1_ff.x != '0);
      s2_in.r2    = ur * ur;
      s2_in.x2    = ux * ux;
      s2_in.tr2   = s1_ff.tr * s1_ff.tr;
      s2_in.ti2   = s1_ff.ti * s1_ff.ti;
      s2_in.num_g = pbc_pkg::NW'(ur) << (2 * pbc_pkg::FB);
      s2_in.num_b = pbc_pkg::NW'(ux) << (2 * pbc_pkg::FB);
      s2_in.bsh   = s1_ff.bsh;
      s2_in.tr    = s1_ff.tr;
      s2_in.ti    = s1_ff.ti;
      s2_in.vkr   = s1_ff.vkr;
      s2_in.vki   = s1_ff.vki;
      s2_in.vmr   = s1_ff.vmr;
      s2_in.vmi   = s1_ff.vmi;
   end

   always_comb begin
      pbc_pkg::sat_type t2;
      t2 = pbc_pkg::quant(pbc_pkg::SW'(s2_ff.tr2) + pbc_pkg::SW'(s2_ff.ti2));
      div_in_in.valid     = v2_ff;
      div_in_in.neg_g     = s2_ff.neg_g;
      div_in_in.neg_b     = s2_ff.neg_b;
      div_in_in.den       = s2_ff.r2 + s2_ff.x2;
      div_in_in.num_g     = s2_ff.num_g;
      div_in_in.num_b     = s2_ff.num_b;
      div_in_in.side.zero = s2_ff.zero;
      div_in_in.side.ovf  = t2.ovf;
      div_in_in.side.bsh  = s2_ff.bsh;
      div_in_in.side.tr   = s2_ff.tr;
      div_in_in.side.ti   = s2_ff.ti;
      div_in_in.side.vkr  = s2_ff.vkr;
      div_in_in.side.vki  = s2_ff.vki;
      div_in_in.side.vmr  = s2_ff.vmr;
      div_in_in.side.vmi  = s2_ff.vmi;
      div_in_in.side.t2   = t2.val;
   end

   pbc_div u_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .din   (div_in_ff),
      .dout  (dout)
   );

   // tap products with y
   always_comb begin
      pbc_pkg::sat_type e;
      e = pbc_pkg::sat_w(pbc_pkg::SW'(dout.b) + pbc_pkg::SW'(dout.side.bsh));
      s4_in.zero = dout.side.zero;
      s4_in.ovf  = dout.side.ovf || dout.ovf || e.ovf;
      s4_in.g    = dout.g;
      s4_in.bsh  = dout.side.bsh;
      s4_in.eim  = e.val;
      s4_in.vkr  = dout.side.vkr;
      s4_in.vki  = dout.side.vki;
      s4_in.vmr  = dout.side.vmr;
      s4_in.vmi  = dout.side.vmi;
      s4_in.pa   = dout.side.t2 * dout.g;
      s4_in.pb   = dout.side.t2 * dout.b;
      s4_in.p1   = dout.side.tr * dout.g;
      s4_in.p2   = dout.side.ti * dout.b;
      s4_in.p3   = dout.side.tr * dout.b;
      s4_in.p4   = dout.side.ti * dout.g;
   end

   always_comb begin
      pbc_pkg::sat_type are, aim, ccr, cci, cdr, cdi;
      are = pbc_pkg::quant(pbc_pkg::SW'(s4_ff.pa));
      aim = pbc_pkg::quant(pbc_pkg::SW'(s4_ff.pb) + (pbc_pkg::SW'(s4_ff.bsh) <<< pbc_pkg::FB));
      ccr = pbc_pkg::quant(pbc_pkg::SW'(s4_ff.p1) + pbc_pkg::SW'(s4_ff.p2));
      cci = pbc_pkg::quant(pbc_pkg::SW'(s4_ff.p3) - pbc_pkg::SW'(s4_ff.p4));
      cdr = pbc_pkg::quant(pbc_pkg::SW'(s4_ff.p1) - pbc_pkg::SW'(s4_ff.p2));
      cdi = pbc_pkg::quant(pbc_pkg::SW'(s4_ff.p3) + pbc_pkg::SW'(s4_ff.p4));
      s5_in.zero = s4_ff.zero;
      s5_in.ovf  = s4_ff.ovf || are.ovf || aim.ovf || ccr.ovf || cci.ovf || cdr.ovf
                   || cdi.ovf;
      s5_in.g    = s4_ff.g;
      s5_in.eim  = s4_ff.eim;
      s5_in.are  = are.val;
      s5_in.aim  = aim.val;
      s5_in.ccr  = ccr.val;
      s5_in.cci  = cci.val;
      s5_in.cdr  = cdr.val;
      s5_in.cdi  = cdi.val;
      s5_in.vkr  = s4_ff.vkr;
      s5_in.vki  = s4_ff.vki;
      s5_in.vmr  = s4_ff.vmr;
      s5_in.vmi  = s4_ff.vmi;
   end

   always_comb begin
      s6_in.zero = s5_ff.zero;
      s6_in.ovf  = s5_ff.ovf;
      s6_in.m0   = s5_ff.are * s5_ff.vkr;
      s6_in.m1   = s5_ff.aim * s5_ff.vki;
      s6_in.m2   = s5_ff.ccr * s5_ff.vmr;
      s6_in.m3   = s5_ff.cci * s5_ff.vmi;
      s6_in.m4   = s5_ff.are * s5_ff.vki;
      s6_in.m5   = s5_ff.aim * s5_ff.vkr;
      s6_in.m6   = s5_ff.ccr * s5_ff.vmi;
      s6_in.m7   = s5_ff.cci * s5_ff.vmr;
      s6_in.m8   = s5_ff.cdi * s5_ff.vki;
      s6_in.m9   = s5_ff.cdr * s5_ff.vkr;
      s6_in.m10  = s5_ff.g * s5_ff.vmr;
      s6_in.m11  = s5_ff.eim * s5_ff.vmi;
      s6_in.m12  = s5_ff.g * s5_ff.vmi;
      s6_in.m13  = s5_ff.eim * s5_ff.vmr;
      s6_in.m14  = s5_ff.cdr * s5_ff.vki;
      s6_in.m15  = s5_ff.cdi * s5_ff.vkr;
   end

   always_comb begin
      s7_in.zero = s6_ff.zero;
      s7_in.ovf  = s6_ff.ovf;
      s7_in.ikr  = pbc_pkg::SW'(s6_ff.m0) - pbc_pkg::SW'(s6_ff.m1)
                   - pbc_pkg::SW'(s6_ff.m2) + pbc_pkg::SW'(s6_ff.m3);
      s7_in.iki  = pbc_pkg::SW'(s6_ff.m4) + pbc_pkg::SW'(s6_ff.m5)
                   - pbc_pkg::SW'(s6_ff.m6) - pbc_pkg::SW'(s6_ff.m7);
      s7_in.imr  = pbc_pkg::SW'(s6_ff.m8) - pbc_pkg::SW'(s6_ff.m9)
                   + pbc_pkg::SW'(s6_ff.m10) - pbc_pkg::SW'(s6_ff.m11);
      s7_in.imi  = pbc_pkg::SW'(s6_ff.m12) + pbc_pkg::SW'(s6_ff.m13)
                   - pbc_pkg::SW'(s6_ff.m14) - pbc_pkg::SW'(s6_ff.m15);
   end

   // zero impedance overrides everything, saturation flags included
   always_comb begin
      pbc_pkg::sat_type q0, q1, q2, q3;
      q0 = pbc_pkg::quant(s7_ff.ikr);
      q1 = pbc_pkg::quant(s7_ff.iki);
      q2 = pbc_pkg::quant(s7_ff.imr);
      q3 = pbc_pkg::quant(s7_ff.imi);
      if (s7_ff.zero) begin
         ikm_re_in = '0;
         ikm_im_in = '0;
         imk_re_in = '0;
         imk_im_in = '0;
         status_in = pbc_pkg::ST_ZERO;
      end else begin
         ikm_re_in = q0.val;
         ikm_im_in = q1.val;
         imk_re_in = q2.val;
         imk_im_in = q3.val;
         status_in = (s7_ff.ovf || q0.ovf || q1.ovf || q2.ovf || q3.ovf) ? pbc_pkg::ST_SAT
                                                                       : pbc_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         s4_ff     <= s4_in;
         s5_ff     <= s5_in;
         s6_ff     <= s6_in;
         s7_ff     <= s7_in;
         ikm_re_ff <= ikm_re_in;
         ikm_im_ff <= ikm_im_in;
         imk_re_ff <= imk_re_in;
         imk_im_ff <= imk_im_in;
         status_ff <= status_in;
      end
      if (reset) begin
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         div_in_ff.valid <= 1'b0;
         v4_ff           <= 1'b0;
         v5_ff           <= 1'b0;
         v6_ff           <= 1'b0;
         v7_ff           <= 1'b0;
         out_vld_ff      <= 1'b0;
      end else if (en) begin
         v1_ff      <= req_ch.valid;
         v2_ff      <= v1_ff;
         div_in_ff  <= div_in_in;
         v4_ff      <= dout.valid;
         v5_ff      <= v4_ff;
         v6_ff      <= v5_ff;
         v7_ff      <= v6_ff;
         out_vld_ff <= v7_ff;
      end
   end

   assign rsp_ch.valid  = out_vld_ff;
   assign rsp_ch.ikm_re = ikm_re_ff;
   assign rsp_ch.ikm_im = ikm_im_ff;
   assign rsp_ch.imk_re = imk_re_ff;
   assign rsp_ch.imk_im = imk_im_ff;
   assign rsp_ch.status = status_ff;

   a_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && status_ff == pbc_pkg::ST_ZERO |->
         ikm_re_ff == '0 && ikm_im_ff == '0 && imk_re_ff == '0 && imk_im_ff == '0)
      else $error("zero impedance response carries nonzero current");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while response stalled");
   a_tail: assert property (@(posedge clock) disable iff (reset)
      en |=> out_vld_ff == $past(v7_ff))
      else $error("response valid out of step with pipeline");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v7_ff) && $stable(status_ff))
      else $error("pipeline tail moved while stalled");

endmodule
